>>> sv/ffsa_pkg.sv
//------------------------------------------------------------------------------
// ffsa_pkg
// Shared types and codes for the free frame stack allocator.
//------------------------------------------------------------------------------
`default_nettype none
package ffsa_pkg;
   typedef enum logic [1:0] {
      ACT_PROTECT = 2'd0,
      ACT_ADD     = 2'd1,
      ACT_ALLOC   = 2'd2,
      ACT_FREE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_OUT_OF_MEM = 2'd1,
      ST_NO_ROOM    = 2'd2,
      ST_TABLE_FULL = 2'd3
   } status_type;

   typedef struct packed {
      action_type  action;
      logic [31:0] address;
      logic [31:0] length;
   } req_type;

   typedef struct packed {
      logic [31:0] frame_address;
      status_type  status;
      logic [10:0] frames_added;
   } rsp_type;
endpackage
`default_nettype wire

>>> sv/ffsa_if.sv
//------------------------------------------------------------------------------
// ffsa_if
// Valid/ready channel carrying one payload word.
//------------------------------------------------------------------------------
`default_nettype none
interface ffsa_if #(parameter int Width = 8);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/ffsa_queue.sv
//------------------------------------------------------------------------------
// ffsa_queue
// Two-entry queue between the front and back parts.
//------------------------------------------------------------------------------
`default_nettype none
module ffsa_queue
   import ffsa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  req_type      push_data,
   output logic         not_full,
   input  wire logic    pop,
   output req_type      pop_data,
   output logic         not_empty
);
   req_type    mem_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign not_full  = (cnt_ff != 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data  = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) mem_ff[wptr_ff] <= push_data;
   end
endmodule
`default_nettype wire

>>> sv/ffsa_engine.sv
//------------------------------------------------------------------------------
// ffsa_engine
// Back part: region table, frame stack memory and the add range walk.
//------------------------------------------------------------------------------
`default_nettype none
module ffsa_engine
   import ffsa_pkg::*;
#(
   parameter int FrameSlots  = 1024,
   parameter int RegionSlots = 32,
   parameter int FrameBytes  = 4096
)(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic cmd_valid,
   input  req_type   cmd,
   output logic      cmd_ready,
   output logic      rsp_valid,
   output rsp_type   rsp,
   input  wire logic rsp_ready
);
   localparam int FW = $clog2(FrameSlots);
   localparam int RW = (RegionSlots > 1) ? $clog2(RegionSlots) : 1;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_CHECK = 6'b000100,
      S_STEP  = 6'b001000,
      S_READ  = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type     state_ff, state_in;
   logic [FW:0]   next_ff, next_in, fill_ff, fill_in;
   logic [RW:0]   rcount_ff, rcount_in;
   logic [RW-1:0] ridx_ff, ridx_in;
   logic [32:0]   off_ff, off_in;
   logic [31:0]   base_ff, base_in, len_ff, len_in;
   logic [31:0]   frame_ff, frame_in;
   logic [10:0]   added_ff, added_in;
   rsp_type       out_ff, out_in;
   logic          ovalid_ff, ovalid_in;

   logic [31:0]   rstart_mem [RegionSlots];
   logic [31:0]   rsize_mem  [RegionSlots];
   logic [31:0]   lo_rd_ff, hi_rd_ff;
   logic [31:0]   fmem [FrameSlots];
   logic [31:0]   frd_ff;

   logic          fwe;
   logic [FW-1:0] fwa, fra;
   logic [31:0]   fwd;
   logic          rwe;
   logic          rd_hit;

   assign cmd_ready = (state_ff == S_IDLE) && !ovalid_ff;
   assign rsp_valid = ovalid_ff;
   assign rsp       = out_ff;
   assign rd_hit    = (frame_ff >= lo_rd_ff) && (frame_ff <= hi_rd_ff);

   always_comb begin
      state_in  = state_ff;
      next_in   = next_ff;
      fill_in   = fill_ff;
      rcount_in = rcount_ff;
      ridx_in   = ridx_ff;
      off_in    = off_ff;
      base_in   = base_ff;
      len_in    = len_ff;
      frame_in  = frame_ff;
      added_in  = added_ff;
      out_in    = out_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      fwe = 1'b0;
      fwa = fill_ff[FW-1:0];
      fwd = frame_ff;
      fra = next_ff[FW-1:0];
      rwe = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               out_in = '{frame_address: 32'd0, status: ST_OK, frames_added: 11'd0};
               case (cmd.action)
                  ACT_PROTECT: begin
                     if (rcount_ff >= (RW+1)'(RegionSlots)) begin
                        out_in.status = ST_TABLE_FULL;
                     end else begin
                        rwe       = 1'b1;
                        rcount_in = rcount_ff + 1'b1;
                     end
                     ovalid_in = 1'b1;
                  end
                  ACT_ADD: begin
                     base_in  = cmd.address;
                     len_in   = cmd.length;
                     off_in   = '0;
                     added_in = '0;
                     state_in = S_STEP;
                  end
                  ACT_ALLOC: begin
                     if (next_ff >= fill_ff) begin
                        out_in.status = ST_OUT_OF_MEM;
                        ovalid_in     = 1'b1;
                     end else begin
                        next_in  = next_ff + 1'b1;
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     if (next_ff == '0) begin
                        out_in.status = ST_NO_ROOM;
                     end else begin
                        next_in = next_ff - 1'b1;
                        fwe     = 1'b1;
                        fwa     = next_in[FW-1:0];
                        fwd     = cmd.address;
                     end
                     ovalid_in = 1'b1;
                  end
               endcase
            end
         end
         S_STEP: begin
            // next frame of the walk, or finish
            if (off_ff >= {1'b0, len_ff}) begin
               out_in.frames_added = added_ff;
               ovalid_in = 1'b1;
               state_in  = S_OUT;
            end else begin
               frame_in = base_ff + off_ff[31:0];
               ridx_in  = '0;
               state_in = (rcount_ff == '0) ? S_CHECK : S_SCAN;
            end
         end
         S_SCAN: begin
            // wait for the registered region table read, then compare in S_CHECK
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (rcount_ff != '0 && !rd_hit && ({1'b0, ridx_ff} + 1'b1) < rcount_ff) begin
               ridx_in  = ridx_ff + 1'b1;
               state_in = S_SCAN;
            end else begin
               off_in   = off_ff + 33'(FrameBytes);
               state_in = S_STEP;
               if (!(rcount_ff != '0 && rd_hit)) begin
                  if (fill_ff >= (FW+1)'(FrameSlots)) begin
                     out_in.status       = ST_NO_ROOM;
                     out_in.frames_added = added_ff;
                     ovalid_in = 1'b1;
                     state_in  = S_OUT;
                  end else begin
                     fwe      = 1'b1;
                     fill_in  = fill_ff + 1'b1;
                     added_in = added_ff + 1'b1;
                  end
               end
            end
         end
         S_READ: begin
            out_in.frame_address = frd_ff;
            ovalid_in = 1'b1;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (!ovalid_ff || rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         next_ff   <= '0;
         fill_ff   <= '0;
         rcount_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         next_ff   <= next_in;
         fill_ff   <= fill_in;
         rcount_ff <= rcount_in;
         ovalid_ff <= ovalid_in;
      end
      ridx_ff  <= ridx_in;
      off_ff   <= off_in;
      base_ff  <= base_in;
      len_ff   <= len_in;
      frame_ff <= frame_in;
      added_ff <= added_in;
      out_ff   <= out_in;
   end

   // region tables
   always_ff @(posedge clock) begin
      if (rwe) begin
         rstart_mem[rcount_ff[RW-1:0]] <= cmd.address;
         rsize_mem[rcount_ff[RW-1:0]]  <= cmd.length;
      end
      lo_rd_ff <= rstart_mem[ridx_in];
      hi_rd_ff <= rstart_mem[ridx_in] + rsize_mem[ridx_in];
   end

   // frame stack memory
   always_ff @(posedge clock) begin
      if (fwe) fmem[fwa] <= fwd;
      frd_ff <= fmem[fra];
   end
endmodule
`default_nettype wire

>>> sv/ffsa_front.sv
//------------------------------------------------------------------------------
// ffsa_front
// Front part: takes request words and pushes them into the queue.
//------------------------------------------------------------------------------
`default_nettype none
module ffsa_front
   import ffsa_pkg::*;
(
   input  wire logic reset,
   ffsa_if.sink      req,
   output logic      push,
   output req_type   push_data,
   input  wire logic not_full
);
   assign req.ready = not_full && !reset;
   assign push      = req.valid && req.ready;
   assign push_data = req_type'(req.data);
endmodule
`default_nettype wire

>>> sv/free_frame_stack_allocator.sv
//------------------------------------------------------------------------------
// free_frame_stack_allocator
// Page frame allocator with a stack of free frame addresses.
//------------------------------------------------------------------------------
// Usage:
//   req_ carries one request word: action, address, length. rsp_ returns
//   exactly one word per request: frame_address, status, frames_added.
//   A front part takes requests into a two-entry queue; a back engine runs
//   them one at a time against the region tables and the frame memory.
//   The response word is registered. Protect and free pass through the
//   queue and the response register; allocate also passes through one
//   registered frame memory read. Add range visits S_STEP for each frame,
//   then S_SCAN (registered region table read) and S_CHECK (compare) for
//   each protected region until one holds the frame, or only S_CHECK when
//   no region is set. The next request starts once the response is taken.
//   Reset clears the stack pointers and the region count; memories are not
//   cleared, so no clearing pass is needed.
//   When rsp_ready is low, the response holds and the engine waits; up to
//   two further requests are still taken into the queue.
//------------------------------------------------------------------------------
`default_nettype none
module free_frame_stack_allocator
   import ffsa_pkg::*;
#(
   parameter int FRAME_SLOTS  = 1024,
   parameter int REGION_SLOTS = 32,
   parameter int FRAME_BYTES  = 4096
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [31:0] req_address,
   input  wire logic [31:0] req_length,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_frame_address,
   output logic [1:0]       rsp_status,
   output logic [10:0]      rsp_frames_added
);
   ffsa_if #(.Width($bits(req_type))) req_ch ();
   req_type push_data, pop_data;
   logic    push, not_full, pop, not_empty, cmd_ready;
   rsp_type rsp;

   assign req_ch.valid = req_valid;
   assign req_ch.data  = {req_action, req_address, req_length};
   assign req_ready    = req_ch.ready;

   ffsa_front u_front (
      .reset, .req(req_ch.sink), .push, .push_data, .not_full
   );

   assign pop = not_empty && cmd_ready;

   ffsa_queue u_queue (
      .clock, .reset, .push, .push_data, .not_full, .pop, .pop_data, .not_empty
   );

   ffsa_engine #(
      .FrameSlots(FRAME_SLOTS), .RegionSlots(REGION_SLOTS), .FrameBytes(FRAME_BYTES)
   ) u_engine (
      .clock, .reset, .cmd_valid(not_empty), .cmd(pop_data), .cmd_ready,
      .rsp_valid, .rsp, .rsp_ready
   );

   assign rsp_frame_address = rsp.frame_address;
   assign rsp_status        = rsp.status;
   assign rsp_frames_added  = rsp.frames_added;
endmodule
`default_nettype wire

>>> sv/ffsa_checker.sv
//------------------------------------------------------------------------------
// ffsa_checker
// Port-level checks for the allocator, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none
module ffsa_checker
   import ffsa_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_frame_address,
   input wire logic [1:0]  rsp_status,
   input wire logic [10:0] rsp_frames_added
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_address))
      else $error("response dropped while stalled");
   a_no_rsp_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response right after reset");
   a_no_req_in_reset: assert property (@(posedge clock)
      reset |-> !(req_valid && req_ready))
      else $error("request word taken during reset");
   a_oom_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OUT_OF_MEM |-> rsp_frame_address == 32'd0
         && rsp_frames_added == 11'd0)
      else $error("out of memory with payload");
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_TABLE_FULL |-> rsp_frame_address == 32'd0)
      else $error("table full with address");
endmodule

bind free_frame_stack_allocator ffsa_checker u_ffsa_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_frame_address, .rsp_status, .rsp_frames_added
);
`default_nettype wire

>>> test/free_frame_stack_allocator_test.sv
//------------------------------------------------------------------------------
// free_frame_stack_allocator_test
// Self-checking bench for the free frame stack allocator: a short table of
// directed requests, then 1100 random requests, every response checked against
// a scripted expected word or a behavioural copy of the frame stack and region table.
//------------------------------------------------------------------------------
`default_nettype none
module free_frame_stack_allocator_test;
   import ffsa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_DEPTH   = 1024;
   localparam int REGION_DEPTH  = 32;
   localparam int PAGE_BYTES    = 4096;
   localparam int RANDOM_ITEMS  = 1100;
   localparam int STALL_LIMIT   = 200000;
   localparam int LONG_HOLD     = 400;
   localparam int HOLD_AFTER    = 200;
   localparam int DRAIN_AT      = 600;

   typedef struct {
      action_type  act;
      logic [31:0] addr;
      logic [31:0] len;
      bit          fixed;
      rsp_type     fixed_rsp;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ffsa_if #(.Width($bits(req_type))) req_ch ();
   ffsa_if #(.Width($bits(rsp_type))) rsp_ch ();

   free_frame_stack_allocator uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_action        (req_ch.data[65:64]),
      .req_address       (req_ch.data[63:32]),
      .req_length        (req_ch.data[31:0]),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_frame_address (rsp_ch.data[44:13]),
      .rsp_status        (rsp_ch.data[12:11]),
      .rsp_frames_added  (rsp_ch.data[10:0])
   );

   always #10 clock = ~clock;

   // allocator state as the bench sees it
   logic [31:0] free_stack [STACK_DEPTH];
   logic [31:0] region_lo  [REGION_DEPTH];
   logic [31:0] region_len [REGION_DEPTH];
   int unsigned pop_ptr;
   int unsigned fill_ptr;
   int unsigned region_total;

   rsp_type        pending_rsp [$];
   script_row_type script [$];
   int             errors;
   int             words_sent;
   int             words_back;
   int             idle_cycles;
   int             action_seen [4];
   int             status_seen [4];

   function automatic bit is_shielded(logic [31:0] frame);
      for (int r = 0; r < region_total; r++) begin
         logic [31:0] hi;
         hi = region_lo[r] + region_len[r];
         if (frame >= region_lo[r] && frame <= hi) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_type allocator_step(req_type w);
      rsp_type     r;
      longint      off;
      logic [31:0] frame;
      r = '{frame_address: '0, status: ST_OK, frames_added: '0};
      case (w.action)
         ACT_PROTECT: begin
            if (region_total >= REGION_DEPTH) begin
               r.status = ST_TABLE_FULL;
            end else begin
               region_lo[region_total]  = w.address;
               region_len[region_total] = w.length;
               region_total++;
            end
         end
         ACT_ADD: begin
            for (off = 0; off < longint'(w.length); off += PAGE_BYTES) begin
               frame = w.address + off[31:0];
               if (is_shielded(frame)) continue;
               if (fill_ptr >= STACK_DEPTH) begin
                  r.status = ST_NO_ROOM;
                  break;
               end
               free_stack[fill_ptr] = frame;
               fill_ptr++;
               r.frames_added++;
            end
         end
         ACT_ALLOC: begin
            if (pop_ptr >= fill_ptr) begin
               r.status = ST_OUT_OF_MEM;
            end else begin
               r.frame_address = free_stack[pop_ptr];
               pop_ptr++;
            end
         end
         default: begin
            if (pop_ptr == 0) begin
               r.status = ST_NO_ROOM;
            end else begin
               pop_ptr--;
               free_stack[pop_ptr] = w.address;
            end
         end
      endcase
      return r;
   endfunction

   function automatic rsp_type rsp_of(logic [31:0] fa, status_type st, logic [10:0] n);
      rsp_type r;
      r.frame_address = fa;
      r.status        = st;
      r.frames_added  = n;
      return r;
   endfunction

   task automatic add_row(action_type act, logic [31:0] addr, logic [31:0] len,
                          bit fixed = 1'b0, rsp_type exp = '0);
      script_row_type row;
      row.act       = act;
      row.addr      = addr;
      row.len       = len;
      row.fixed     = fixed;
      row.fixed_rsp = exp;
      script.push_back(row);
   endtask

   // offer one word, hold it until taken, then record what it should return
   task automatic send_word(req_type w, bit fixed, rsp_type exp);
      rsp_type predicted;
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.data  <= w;
      forever begin
         @(posedge clock);
         if (req_ch.ready) break;
      end
      predicted = allocator_step(w);
      pending_rsp.push_back(fixed ? exp : predicted);
      action_seen[w.action]++;
      words_sent++;
   endtask

   task automatic idle_for(int n);
      repeat (n) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
   endtask

   function automatic req_type random_word();
      req_type     w;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      w.address = $urandom_range(0, 255) << 12;
      w.length  = $urandom_range(0, 16) * PAGE_BYTES;
      if (pick < 8) begin
         w.action = ACT_PROTECT;
         w.length = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 32'h8000) : $urandom;
         if ($urandom_range(0, 4) == 0) w.address = $urandom;
      end else if (pick < 33) begin
         w.action = ACT_ADD;
         if ($urandom_range(0, 3) == 0) w.length = $urandom_range(0, 32'h10000);
         if ($urandom_range(0, 9) == 0) w.address = $urandom;
         // a long walk is only affordable when it stops at its first frame
         if (fill_ptr >= STACK_DEPTH && !is_shielded(w.address) &&
             $urandom_range(0, 1) == 0)
            w.length = $urandom;
      end else if (pick < 68) begin
         w.action = ACT_ALLOC;
         w.address = $urandom;
         w.length  = $urandom;
      end else begin
         w.action = ACT_FREE;
         if ($urandom_range(0, 3) == 0) w.address = $urandom;
         w.length = $urandom;
      end
      return w;
   endfunction

   // response checker
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         words_back++;
         if (pending_rsp.size() == 0) begin
            $error("response word with nothing outstanding: %h", got);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            status_seen[got.status]++;
            if (got.frame_address !== want.frame_address) begin
               $error("frame_address: expected %h, got %h",
                      want.frame_address, got.frame_address);
               errors++;
            end
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               errors++;
            end
            if (got.frames_added !== want.frames_added) begin
               $error("frames_added: expected %0d, got %0d",
                      want.frames_added, got.frames_added);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver: changing stall patterns, plus one long hold-off
   initial begin
      int  mode;
      int  k;
      bit  held;
      held = 1'b0;
      k    = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(16, 96)) begin
            @(negedge clock);
            k++;
            if (!held && words_sent >= HOLD_AFTER) begin
               held = 1'b1;
               rsp_ch.ready <= 1'b0;
               repeat (LONG_HOLD) @(negedge clock);
            end
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= $urandom_range(0, 1);
               default: rsp_ch.ready <= (k % 3 == 0);
            endcase
         end
      end
   end

   initial begin
      req_type w;
      int      burst;
      int      n;
      errors      = 0;
      words_sent  = 0;
      words_back  = 0;
      idle_cycles = 0;
      pop_ptr     = 0;
      fill_ptr    = 0;
      region_total = 0;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;

      add_row(ACT_ALLOC,   32'h0,        32'h0,        1, rsp_of(0, ST_OUT_OF_MEM, 0));
      add_row(ACT_FREE,    32'h1234,     32'h0,        1, rsp_of(0, ST_NO_ROOM, 0));
      add_row(ACT_ADD,     32'h5000,     32'h0,        1, rsp_of(0, ST_OK, 0));
      add_row(ACT_PROTECT, 32'h10000,    32'h1fff,     1, rsp_of(0, ST_OK, 0));
      add_row(ACT_PROTECT, 32'hfffff000, 32'h2000,     1, rsp_of(0, ST_OK, 0));
      add_row(ACT_PROTECT, 32'h20000,    32'h0,        1, rsp_of(0, ST_OK, 0));
      add_row(ACT_PROTECT, 32'hffffffff, 32'hffffffff, 1, rsp_of(0, ST_OK, 0));
      add_row(ACT_ADD,     32'hf000,     32'h5000);
      add_row(ACT_ADD,     32'h1f000,    32'h3000);
      // range running across the top of the address space
      add_row(ACT_ADD,     32'hffffe000, 32'h3000);
      add_row(ACT_ADD,     32'h30001,    32'h1001);
      add_row(ACT_ADD,     32'hffffffff, 32'h1);
      add_row(ACT_ALLOC,   32'h0,        32'h0);
      add_row(ACT_ALLOC,   32'hffffffff, 32'hffffffff);
      add_row(ACT_ALLOC,   32'h0,        32'h0);
      add_row(ACT_FREE,    32'hffffffff, 32'h0);
      add_row(ACT_FREE,    32'h00000001, 32'hffffffff);
      add_row(ACT_ALLOC,   32'h0,        32'h0);
      add_row(ACT_ALLOC,   32'h0,        32'h0);
      add_row(ACT_ALLOC,   32'h0,        32'h0);
      add_row(ACT_ALLOC,   32'h0,        32'h0);
      add_row(ACT_ALLOC,   32'h0,        32'h0);
      add_row(ACT_ALLOC,   32'h0,        32'h0);
      add_row(ACT_ALLOC,   32'h0,        32'h0);
      add_row(ACT_ALLOC,   32'h0,        32'h0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         w.action  = script[i].act;
         w.address = script[i].addr;
         w.length  = script[i].len;
         send_word(w, script[i].fixed, script[i].fixed_rsp);
      end

      n = 0;
      while (n < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 20);
         repeat (burst) begin
            if (n == DRAIN_AT) begin
               idle_for(1);
               while (pending_rsp.size() != 0) @(posedge clock);
            end
            send_word(random_word(), 1'b0, '0);
            n++;
         end
         if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 6));
      end
      idle_for(1);

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("sent %0d words: %0d protect, %0d add, %0d allocate, %0d free",
               words_sent, action_seen[ACT_PROTECT], action_seen[ACT_ADD],
               action_seen[ACT_ALLOC], action_seen[ACT_FREE]);
      $display("statuses ok %0d, out of memory %0d, no room %0d, table full %0d",
               status_seen[ST_OK], status_seen[ST_OUT_OF_MEM],
               status_seen[ST_NO_ROOM], status_seen[ST_TABLE_FULL]);
      if (errors == 0 && words_back == words_sent) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire
